/* sv/indexed_bank_register_mapper_core_defines.svh */
// assertion macros for the indexed bank register mapper
`ifndef INDEXED_BANK_REGISTER_MAPPER_CORE_DEFINES_SVH
`define INDEXED_BANK_REGISTER_MAPPER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define IBRM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ibrm check failed");
`define IBRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ibrm check failed");
`else
`define IBRM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define IBRM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* sv/ibrm_pkg.sv */
// types and constants shared by the indexed bank register mapper
package ibrm_pkg;

  localparam logic [15:0] PORT_MASK  = 16'hC101;
  localparam logic [15:0] PORT_INDEX = 16'h4100;
  localparam logic [15:0] PORT_DATA  = 16'h4101;

  // register index codes on the data port
  localparam logic [2:0] REG_CHR0     = 3'd0;
  localparam logic [2:0] REG_CHR3     = 3'd3;
  localparam logic [2:0] REG_CHR_HIGH = 3'd4;
  localparam logic [2:0] REG_PRG      = 3'd5;
  localparam logic [2:0] REG_EXTRA    = 3'd6;
  localparam logic [2:0] REG_MODE     = 3'd7;

  // bank formula codes
  localparam logic [1:0] VARIANT_1K   = 2'd0;
  localparam logic [1:0] VARIANT_2K_A = 2'd1;
  localparam logic [1:0] VARIANT_2K_B = 2'd2;
  localparam logic [1:0] VARIANT_2K_C = 2'd3;

  // mirror select and layout codes
  localparam logic [1:0] MIRROR_DEFAULT = 2'd0;
  localparam logic [1:0] MIRROR_OTHER   = 2'd1;
  localparam logic [1:0] MIRROR_SPLIT   = 2'd2;

  localparam logic [1:0] LAYOUT_HORIZONTAL   = 2'd0;
  localparam logic [1:0] LAYOUT_VERTICAL     = 2'd1;
  localparam logic [1:0] LAYOUT_SPLIT        = 2'd2;
  localparam logic [1:0] LAYOUT_SINGLE_LOWER = 2'd3;

  // configuration register word index
  localparam logic CFG_VARIANT = 1'b0;

  typedef struct packed {
    logic [15:0] cpu_address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0] prg_bank;
    logic [7:0] chr_bank_0;
    logic [7:0] chr_bank_1;
    logic [7:0] chr_bank_2;
    logic [7:0] chr_bank_3;
    logic [1:0] nametable_layout;
    logic       layout_valid;
  } out_item_t;

  typedef struct packed {
    logic [2:0]       register_index;
    logic [3:0][2:0]  chr_low;
    logic [2:0]       chr_high;
    logic             chr_extra;
    logic             single_bank_mode;
    logic [1:0]       mirror_select;
    logic [2:0]       program_bank;
    logic             layout_written;
  } map_state_t;

endpackage

/* sv/indexed_bank_register_mapper_core.sv */
// indexed bank register mapper: an item is accepted into the input register and its
// result is registered into the output register once the output can advance
// throughput is one item per cycle while the output is not stalled, set by the
// single decode and formula pass between the input and output registers; a held
// result lets one more item into the input register and then stalls the input until the result is taken
// synchronous reset clears all mapper registers, the variant and both valid flags
module indexed_bank_register_mapper_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ibrm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output ibrm_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ibrm_pkg::*;

  logic       s1_valid;
  in_item_t   s1_item;
  logic       advance;
  logic       wr_en;
  logic [1:0] variant;
  map_state_t state_next;
  out_item_t  result;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign wr_en    = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      out_item <= result;
    end
  end

  ibrm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .variant (variant)
  );

  ibrm_regfile u_regfile (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .item       (s1_item),
    .state_next (state_next)
  );

  ibrm_bank_calc u_bank_calc (
    .variant (variant),
    .state   (state_next),
    .result  (result)
  );

endmodule

/* sv/ibrm_cfg.sv */
// apb configuration port holding the variant register
module ibrm_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [1:0]  variant
);
  import ibrm_pkg::*;

  logic wr_variant;

  assign pready = 1'b1;
  // bit 2 is the word index, low bits are the byte offset
  assign wr_variant = psel && penable && pwrite && (paddr[2] == CFG_VARIANT);

  always_ff @(posedge clk) begin
    if (rst) begin
      variant <= VARIANT_1K;
    end else if (wr_variant) begin
      variant <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == CFG_VARIANT) begin
      prdata = {30'd0, variant};
    end
  end

endmodule

/* sv/ibrm_regfile.sv */
// port decode and mapper register file
`include "indexed_bank_register_mapper_core_defines.svh"
module ibrm_regfile (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  ibrm_pkg::in_item_t   item,
  output ibrm_pkg::map_state_t state_next
);
  import ibrm_pkg::*;

  map_state_t  state;
  logic [15:0] port;

  assign port = item.cpu_address & PORT_MASK;

  // state as it stands after this item's write
  always_comb begin
    state_next = state;
    if (port == PORT_INDEX) begin
      state_next.register_index = item.write_data[2:0];
    end else if (port == PORT_DATA) begin
      case (state.register_index) inside
        [REG_CHR0:REG_CHR3]: begin
          state_next.chr_low[state.register_index[1:0]] = item.write_data[2:0];
        end
        REG_CHR_HIGH: begin
          state_next.chr_high = item.write_data[2:0];
        end
        REG_PRG: begin
          state_next.program_bank = item.write_data[2:0];
        end
        REG_EXTRA: begin
          state_next.chr_extra = item.write_data[0];
        end
        default: begin
          state_next.single_bank_mode = item.write_data[0];
          state_next.mirror_select    = item.write_data[2:1];
          state_next.layout_written   = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (wr_en) begin
      state <= state_next;
    end
  end

  `IBRM_ASSERT_NEXT(index_write_a, clk, rst, wr_en && (port == PORT_INDEX), state.register_index == $past(item.write_data[2:0]))
  `IBRM_ASSERT_NEXT(layout_sticky_a, clk, rst, state.layout_written, state.layout_written)
  `IBRM_ASSERT_NEXT(other_port_hold_a, clk, rst, wr_en && (port != PORT_INDEX) && (port != PORT_DATA), state == $past(state))
  `IBRM_ASSERT_IMPL(low_only_on_data_a, clk, rst, port != PORT_DATA, state_next.chr_low == state.chr_low)

endmodule

/* sv/ibrm_bank_calc.sv */
// bank number and nametable layout formulas
module ibrm_bank_calc (
  input  logic [1:0]           variant,
  input  ibrm_pkg::map_state_t state,
  output ibrm_pkg::out_item_t  result
);
  import ibrm_pkg::*;

  logic [3:0][2:0] low;
  logic [3:0][7:0] bank;
  logic [3:0]      high_sel;
  logic [3:0]      extra_sel;
  logic [3:0][1:0] slot;
  logic            swapped;

  // per-slot high bit and extra bit in variant 0, slot 0 takes neither
  assign high_sel  = {state.chr_high, 1'b0};
  assign extra_sel = {state.chr_extra, 3'b000};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      slot[i] = 2'(i);
      low[i]  = state.single_bank_mode ? state.chr_low[0] : state.chr_low[i];
      case (variant)
        VARIANT_1K: begin
          bank[i] = {5'd0, low[i]};
          if (!state.single_bank_mode) begin
            bank[i][4] = high_sel[i];
            bank[i][3] = extra_sel[i];
          end
        end
        VARIANT_2K_A: begin
          bank[i] = {2'd0, state.chr_high, low[i]};
        end
        VARIANT_2K_B: begin
          bank[i] = {state.chr_high, low[i], slot[i]};
        end
        default: begin
          bank[i] = {1'b0, state.chr_high, low[i], slot[i][0]};
        end
      endcase
    end
  end

  assign swapped = (variant == VARIANT_1K);

  always_comb begin
    result.prg_bank     = state.program_bank;
    result.chr_bank_0   = bank[0];
    result.chr_bank_1   = bank[1];
    result.chr_bank_2   = bank[2];
    result.chr_bank_3   = bank[3];
    result.layout_valid = state.layout_written;
    if (!state.layout_written) begin
      result.nametable_layout = LAYOUT_HORIZONTAL;
    end else if (state.mirror_select == MIRROR_DEFAULT || state.single_bank_mode) begin
      result.nametable_layout = swapped ? LAYOUT_HORIZONTAL : LAYOUT_VERTICAL;
    end else if (state.mirror_select == MIRROR_OTHER) begin
      result.nametable_layout = swapped ? LAYOUT_VERTICAL : LAYOUT_HORIZONTAL;
    end else if (state.mirror_select == MIRROR_SPLIT) begin
      result.nametable_layout = LAYOUT_SPLIT;
    end else begin
      result.nametable_layout = LAYOUT_SINGLE_LOWER;
    end
  end

endmodule
